FILE: hdl/sfp_pkg.sv
// shared types and constants for the sensor frame parser
package sfp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned FRAME_LEN   = 10;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned STORE_DEPTH = 7;
    localparam int unsigned STORE_AW    = 3;
    localparam int unsigned WAIT_W      = 9;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'hAB;

    localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd1;

    localparam logic [BYTE_W-1:0] TRY_LIMIT_RST = 8'd10;
    localparam logic [BYTE_W-1:0] TIMEOUT_RST   = 8'd5;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CHECKSUM  = 2'd1,
        ST_NO_HEADER = 2'd2,
        ST_TIMEOUT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HUNT    = 2'd1,
        PH_COLLECT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] try_limit;
        logic [BYTE_W-1:0] timeout_seconds;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [1:0]        action;
        logic [BYTE_W-1:0] rx_byte;
    } t_stage;

endpackage

FILE: hdl/sfp_intf.sv
// channel interfaces: input items, results and configuration writes
interface sfp_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [sfp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, action, rx_byte, input ready);
    modport sink (input valid, action, rx_byte, output ready);
endinterface

interface sfp_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [sfp_pkg::WORD_W-1:0] pm25_tenths;
    logic [sfp_pkg::WORD_W-1:0] pm10_tenths;
    logic [sfp_pkg::WORD_W-1:0] sensor_id;

    modport source (output valid, status, pm25_tenths, pm10_tenths, sensor_id, input ready);
    modport sink (input valid, status, pm25_tenths, pm10_tenths, sensor_id, output ready);
endinterface

interface sfp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sfp_pkg::CFG_IDX_W-1:0] index;
    logic [sfp_pkg::BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/sfp_cfg_regs.sv
// configuration registers: try limit and header timeout
module sfp_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfp_cfg_if.sink       i_cfg,
    output sfp_pkg::t_cfg o_cfg
);
    import sfp_pkg::*;

    logic [BYTE_W-1:0] r_try_limit;
    logic [BYTE_W-1:0] r_timeout;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_try_limit <= TRY_LIMIT_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_TRY_LIMIT) begin
                r_try_limit <= i_cfg.data;
            end
            if (i_cfg.index == CFG_TIMEOUT) begin
                r_timeout <= i_cfg.data;
            end
        end
    end

    assign o_cfg.try_limit       = r_try_limit;
    assign o_cfg.timeout_seconds = r_timeout;

endmodule

FILE: hdl/sfp_in_stage.sv
// input register stage in front of the frame logic
module sfp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sfp_in_if.sink          i_in,
    input  logic            i_stage_ready,
    output sfp_pkg::t_stage o_stage
);
    import sfp_pkg::*;

    logic              r_valid;
    logic [1:0]        r_action;
    logic [BYTE_W-1:0] r_rx_byte;
    logic              in_ready;

    assign in_ready   = !r_valid || i_stage_ready;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_action  <= i_in.action;
            r_rx_byte <= i_in.rx_byte;
        end
    end

    assign o_stage.valid   = r_valid;
    assign o_stage.action  = r_action;
    assign o_stage.rx_byte = r_rx_byte;

endmodule

FILE: hdl/sfp_core.sv
// frame hunt and collect state machine, frame store and result register
module sfp_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfp_pkg::t_cfg   i_cfg,
    input  sfp_pkg::t_stage i_stage,
    output logic            o_stage_ready,
    sfp_out_if.source       o_res
);
    import sfp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [IDX_W-1:0]  r_byte_idx, n_byte_idx;
    logic [BYTE_W-1:0] r_fails, n_fails;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic [BYTE_W-1:0] r_store [STORE_DEPTH];

    logic              r_out_valid;
    t_status           r_status;
    logic [WORD_W-1:0] r_pm25;
    logic [WORD_W-1:0] r_pm10;
    logic [WORD_W-1:0] r_id;

    logic                take;
    logic                res_load;
    t_status             res_status;
    logic                res_data;
    logic                store_we;
    logic [STORE_AW-1:0] store_addr;
    logic [BYTE_W-1:0]   fail_limit;
    logic [BYTE_W-1:0]   fails_inc;
    logic                fail_end;
    logic [WAIT_W-1:0]   wait_inc;
    logic [BYTE_W-1:0]   sum;

    assign o_stage_ready = !r_out_valid || o_res.ready;
    assign take          = i_stage.valid && o_stage_ready;

    // a failed attempt ends the read once the count reaches try_limit - 1 (at least one)
    assign fail_limit = (i_cfg.try_limit < 8'd2) ? 8'd1 : i_cfg.try_limit - 8'd1;
    assign fails_inc  = (r_fails == '1) ? r_fails : r_fails + 8'd1;
    assign fail_end   = fails_inc >= fail_limit;
    assign wait_inc   = (r_wait == '1) ? r_wait : r_wait + 9'd1;

    always_comb begin
        sum = '0;
        for (int i = 0; i < STORE_DEPTH - 1; i++) begin
            sum = sum + r_store[i];
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_byte_idx = r_byte_idx;
        n_fails    = r_fails;
        n_wait     = r_wait;
        res_load   = 1'b0;
        res_status = ST_OK;
        res_data   = 1'b0;
        store_we   = 1'b0;
        store_addr = STORE_AW'(r_byte_idx - 4'd2);
        if (take) begin
            case (i_stage.action)
                ACT_START: begin
                    n_phase    = PH_HUNT;
                    n_byte_idx = '0;
                    n_fails    = '0;
                    n_wait     = '0;
                end
                ACT_TICK: begin
                    if (r_phase == PH_HUNT) begin
                        n_wait = wait_inc;
                        if (wait_inc > WAIT_W'(i_cfg.timeout_seconds)) begin
                            n_phase    = PH_IDLE;
                            n_wait     = '0;
                            res_load   = 1'b1;
                            res_status = ST_TIMEOUT;
                        end
                    end
                end
                ACT_BYTE: begin
                    case (r_phase)
                        PH_HUNT: begin
                            if (i_stage.rx_byte == HDR_BYTE) begin
                                n_phase    = PH_COLLECT;
                                n_byte_idx = 4'd1;
                                n_wait     = '0;
                            end else begin
                                n_fails    = fails_inc;
                                n_wait     = '0;
                                n_byte_idx = '0;
                                n_phase    = fail_end ? PH_IDLE : PH_HUNT;
                                res_load   = fail_end;
                                res_status = ST_NO_HEADER;
                            end
                        end
                        PH_COLLECT: begin
                            // bytes 2..8 land in the store, byte 9 is the tail
                            store_we = (r_byte_idx >= 4'd2) && (r_byte_idx <= 4'd8);
                            if (r_byte_idx < IDX_W'(FRAME_LEN - 1)) begin
                                n_byte_idx = r_byte_idx + 4'd1;
                            end else if (i_stage.rx_byte == TAIL_BYTE) begin
                                n_phase    = PH_IDLE;
                                n_byte_idx = '0;
                                n_wait     = '0;
                                res_load   = 1'b1;
                                res_data   = 1'b1;
                                res_status = (sum == r_store[STORE_DEPTH-1]) ?
                                             ST_OK : ST_CHECKSUM;
                            end else begin
                                n_fails    = fails_inc;
                                n_wait     = '0;
                                n_byte_idx = '0;
                                n_phase    = fail_end ? PH_IDLE : PH_HUNT;
                                res_load   = fail_end;
                                res_status = ST_NO_HEADER;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_byte_idx <= '0;
            r_fails    <= '0;
            r_wait     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_byte_idx <= n_byte_idx;
            r_fails    <= n_fails;
            r_wait     <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_addr] <= i_stage.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res_load;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_load) begin
            r_status <= res_status;
            r_pm25   <= res_data ? {r_store[1], r_store[0]} : '0;
            r_pm10   <= res_data ? {r_store[3], r_store[2]} : '0;
            r_id     <= res_data ? {r_store[5], r_store[4]} : '0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.pm25_tenths = r_pm25;
    assign o_res.pm10_tenths = r_pm10;
    assign o_res.sensor_id   = r_id;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx <= IDX_W'(FRAME_LEN - 1))
        else $error("byte index past the frame tail");

    a_idx_outside_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_COLLECT |-> r_byte_idx == '0)
        else $error("byte index left nonzero outside frame collection");

    a_wait_only_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HUNT |-> r_wait == '0)
        else $error("tick count nonzero while not hunting");

    a_error_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_NO_HEADER || r_status == ST_TIMEOUT)
        |-> r_pm25 == '0 && r_pm10 == '0 && r_id == '0)
        else $error("error result carries nonzero payload");

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_stage.valid))
        else $error("result appeared without a staged transaction");

endmodule

FILE: hdl/sensor_frame_parser.sv
// Serial frame parser for a particulate sensor. A start transaction arms a read; received
// bytes are hunted for the 0xAA header and a 10-byte frame is collected, then a result gives
// ok or checksum bad with raw PM2.5, PM10 (tenths) and ID, or no header / timeout with zero
// fields. One input transaction can be taken every clock cycle as long as results are taken;
// a result left waiting on o_res holds the input. The edge that accepts a transaction loads
// the input register; the result register loads from the combinational frame logic when the
// core takes that staged transaction. Configuration writes take effect at the edge that
// accepts them; the user must make them while no read is active: the block does not check.
module sensor_frame_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfp_in_if.sink    i_in,
    sfp_out_if.source o_res,
    sfp_cfg_if.sink   i_cfg
);
    import sfp_pkg::*;

    t_cfg   cfg;
    t_stage stage;
    logic   stage_ready;

    sfp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    sfp_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_stage_ready (stage_ready),
        .o_stage       (stage)
    );

    sfp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_stage       (stage),
        .o_stage_ready (stage_ready),
        .o_res         (o_res)
    );

endmodule

FILE: tb/sensor_frame_parser_tb.sv
// testbench for sensor_frame_parser: directed and random reads checked against a frame predictor
module sensor_frame_parser_tb;
    import sfp_pkg::*;

    localparam logic [1:0] ACT_RESERVED   = 2'd3;
    localparam int         RESULT_LATENCY = 2;
    localparam int         QUIET_CYCLES   = 4 * RESULT_LATENCY;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         ITEM_GOAL      = 1300;
    localparam int         PHASES         = 8;
    localparam int         MAX_PRINTED    = 50;

    typedef struct {
        t_status           status;
        logic [WORD_W-1:0] pm25;
        logic [WORD_W-1:0] pm10;
        logic [WORD_W-1:0] id;
    } t_reading;

    class frame_scoreboard;
        logic [BYTE_W-1:0] try_limit;
        logic [BYTE_W-1:0] timeout_secs;
        t_phase            phase;
        logic [IDX_W-1:0]  byte_idx;
        logic [7:0]        failed_tries;
        logic [WAIT_W-1:0] wait_ticks;
        logic [BYTE_W-1:0] frame_bytes [STORE_DEPTH];
        t_reading          expected_readings [$];
        int                counted_items;
        int                errors;

        function new();
            try_limit     = TRY_LIMIT_RST;
            timeout_secs  = TIMEOUT_RST;
            phase         = PH_IDLE;
            byte_idx      = '0;
            failed_tries  = '0;
            wait_ticks    = '0;
            counted_items = 0;
            errors        = 0;
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
            if (idx == CFG_TRY_LIMIT) begin
                try_limit = value;
            end else if (idx == CFG_TIMEOUT) begin
                timeout_secs = value;
            end
        endfunction

        function void expect_reading(t_status st, logic [WORD_W-1:0] pm25,
                                     logic [WORD_W-1:0] pm10, logic [WORD_W-1:0] id);
            t_reading r;
            r.status = st;
            r.pm25   = pm25;
            r.pm10   = pm10;
            r.id     = id;
            expected_readings.push_back(r);
        endfunction

        // the read gives up once the failed count reaches try_limit - 1 (at least one)
        function void fail_attempt();
            logic [8:0] limit;
            limit = (try_limit < 2) ? 9'd1 : {1'b0, try_limit} - 9'd1;
            if (failed_tries != 8'hFF) failed_tries++;
            wait_ticks = '0;
            byte_idx   = '0;
            if ({1'b0, failed_tries} >= limit) begin
                phase = PH_IDLE;
                expect_reading(ST_NO_HEADER, '0, '0, '0);
            end else begin
                phase = PH_HUNT;
            end
        endfunction

        function void note_rx_item(logic [1:0] act, logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] sum;
            int                i;
            sum = '0;
            counted_items++;
            if (act == ACT_START) begin
                phase        = PH_HUNT;
                byte_idx     = '0;
                failed_tries = '0;
                wait_ticks   = '0;
            end else if (act == ACT_TICK && phase == PH_HUNT) begin
                if (wait_ticks != '1) wait_ticks++;
                if (wait_ticks > timeout_secs) begin
                    phase      = PH_IDLE;
                    wait_ticks = '0;
                    expect_reading(ST_TIMEOUT, '0, '0, '0);
                end
            end else if (act == ACT_BYTE && phase == PH_HUNT) begin
                if (b == HDR_BYTE) begin
                    phase      = PH_COLLECT;
                    byte_idx   = 4'd1;
                    wait_ticks = '0;
                end else begin
                    fail_attempt();
                end
            end else if (act == ACT_BYTE && phase == PH_COLLECT) begin
                if (byte_idx >= 2 && byte_idx <= 8) frame_bytes[byte_idx - 2] = b;
                if (byte_idx < FRAME_LEN - 1) begin
                    byte_idx++;
                end else if (b == TAIL_BYTE) begin
                    for (i = 0; i < 6; i++) sum += frame_bytes[i];
                    phase      = PH_IDLE;
                    byte_idx   = '0;
                    wait_ticks = '0;
                    expect_reading((sum == frame_bytes[6]) ? ST_OK : ST_CHECKSUM,
                                   {frame_bytes[1], frame_bytes[0]},
                                   {frame_bytes[3], frame_bytes[2]},
                                   {frame_bytes[5], frame_bytes[4]});
                end else begin
                    fail_attempt();
                end
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_reading(logic [1:0] st, logic [WORD_W-1:0] pm25,
                           logic [WORD_W-1:0] pm10, logic [WORD_W-1:0] id);
            t_reading want;
            if (expected_readings.size() == 0) begin
                report($sformatf("result with nothing expected, status %0d", st));
            end else begin
                want = expected_readings.pop_front();
                if (st !== want.status)
                    report($sformatf("status %0d, expected %0d", st, want.status));
                if (pm25 !== want.pm25)
                    report($sformatf("pm25_tenths %h, expected %h", pm25, want.pm25));
                if (pm10 !== want.pm10)
                    report($sformatf("pm10_tenths %h, expected %h", pm10, want.pm10));
                if (id !== want.id)
                    report($sformatf("sensor_id %h, expected %h", id, want.id));
            end
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    bit              calm;
    int              stall_cycles = 0;
    frame_scoreboard sb = new();

    sfp_in_if  in_ch ();
    sfp_out_if res_ch ();
    sfp_cfg_if cfg_ch ();

    sensor_frame_parser u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
    end

    // every transaction on any channel is seen here at the edge that completes it
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) sb.note_config(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready) sb.note_rx_item(in_ch.action, in_ch.rx_byte);
            if (res_ch.valid && res_ch.ready)
                sb.check_reading(res_ch.status, res_ch.pm25_tenths, res_ch.pm10_tenths,
                                 res_ch.sensor_id);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("sensor_frame_parser_tb: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom);
    endfunction

    task automatic send_item(logic [1:0] act, logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(0, 99) < 9) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= act;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // header, random byte 1, six data bytes, checksum and tail; messy frames get stray items
    task automatic send_frame(logic [47:0] body, bit sum_ok, logic [BYTE_W-1:0] tail,
                              bit messy);
        logic [BYTE_W-1:0] frame [FRAME_LEN];
        logic [BYTE_W-1:0] sum;
        logic [1:0]        junk;
        int                i;
        int                r;
        sum      = '0;
        frame[0] = HDR_BYTE;
        frame[1] = rand_byte();
        for (i = 0; i < 6; i++) begin
            frame[i + 2] = body[8*i +: 8];
            sum += body[8*i +: 8];
        end
        frame[8] = sum_ok ? sum : sum ^ BYTE_W'($urandom_range(1, 255));
        frame[9] = tail;
        for (i = 0; i < FRAME_LEN; i++) begin
            if (messy && $urandom_range(0, 24) == 0) begin
                r = $urandom_range(0, 9);
                if (r < 5) junk = ACT_TICK;
                else if (r < 8) junk = ACT_RESERVED;
                else junk = ACT_START;
                send_item(junk, rand_byte());
            end
            send_item(ACT_BYTE, frame[i]);
        end
    endtask

    task automatic random_read();
        logic [47:0]       body;
        logic [BYTE_W-1:0] b;
        int                noise;
        int                r;
        int                i;
        if ($urandom_range(0, 9) != 0) send_item(ACT_START, rand_byte());
        r = $urandom_range(0, 9);
        noise = (r < 6) ? 0 : r - 5;
        for (i = 0; i < noise; i++) begin
            r = $urandom_range(0, 5);
            if (r < 2) begin
                send_item(ACT_TICK, rand_byte());
            end else if (r == 2) begin
                send_item(ACT_RESERVED, rand_byte());
            end else begin
                b = rand_byte();
                if (b == HDR_BYTE) b = ~b;
                send_item(ACT_BYTE, b);
            end
        end
        for (i = 0; i < 6; i++) begin
            r = $urandom_range(0, 7);
            body[8*i +: 8] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : rand_byte();
        end
        b = ($urandom_range(0, 6) == 0) ? rand_byte() : TAIL_BYTE;
        send_frame(body, $urandom_range(0, 3) != 0, b, 1'b1);
    endtask

    // bring the read to an end, then wait out every pending result
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.phase != PH_IDLE) begin
            if (sb.phase == PH_COLLECT) send_item(ACT_BYTE, 8'h00);
            else send_item(ACT_TICK, 8'h00);
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        while (sb.expected_readings.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(logic [BYTE_W-1:0] tries, logic [BYTE_W-1:0] tmo);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_TRY_LIMIT;
        cfg_ch.data  <= tries;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.index <= CFG_TIMEOUT;
        cfg_ch.data  <= tmo;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int                k;
        logic [BYTE_W-1:0] tries;
        logic [BYTE_W-1:0] tmo;
        calm          = 1'b0;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.action <= ACT_START;
        in_ch.rx_byte <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_TRY_LIMIT;
        cfg_ch.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // idle ignores bytes, ticks and the reserved action
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_RESERVED, 8'hAA);
        // one failed try, a tick while hunting, then a full-scale good frame
        send_item(ACT_START, 8'h00);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_TICK, 8'hFF);
        send_frame({6{8'hFF}}, 1'b1, TAIL_BYTE, 1'b0);
        // restart while active, then an all-zero frame with a bad checksum
        send_item(ACT_START, 8'hFF);
        send_item(ACT_START, 8'h00);
        send_frame('0, 1'b0, TAIL_BYTE, 1'b0);

        for (k = 0; k < PHASES; k++) begin
            case (k)
                0: begin tries = 8'd2;   tmo = 8'd0;   end
                1: begin tries = 8'd255; tmo = 8'd255; end
                2: begin tries = 8'd0;   tmo = 8'd3;   end
                3: begin tries = 8'd1;   tmo = 8'd1;   end
                4: begin tries = 8'd3;   tmo = 8'd2;   end
                default: begin
                    tries = BYTE_W'($urandom_range(2, 16));
                    tmo   = BYTE_W'($urandom_range(0, 12));
                end
            endcase
            settle();
            write_limits(tries, tmo);
            calm = (k == 4);
            if (k == 0) begin
                // timeout on the first tick, no header on one stray byte and on a bad tail
                send_item(ACT_START, 8'h00);
                send_item(ACT_TICK, 8'h00);
                send_item(ACT_START, 8'h00);
                send_item(ACT_BYTE, 8'h55);
                send_item(ACT_START, 8'h00);
                send_frame(48'h0102_0304_0506, 1'b1, 8'h00, 1'b0);
            end
            while (sb.counted_items < ITEM_GOAL * (k + 1) / PHASES) random_read();
        end
        calm = 1'b0;
        settle();

        if (sb.errors == 0) begin
            $display("sensor_frame_parser_tb: clean");
        end else begin
            $display("sensor_frame_parser_tb: errors");
        end
        $finish;
    end

endmodule
